// ===== rtl/dmst_pkg.sv =====
// Package for the dead-man switch timer: widths, register codes, reset values
// and the transaction and configuration structs. No dependencies.
package dmst_pkg;

   localparam int TIME_W = 32;
   localparam int CFG_W  = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BEEP_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_DELAY = 2'd2;

   localparam logic [CFG_W-1:0] TOLERANCE_RESET   = 16'd5000;
   localparam logic [CFG_W-1:0] BEEP_LENGTH_RESET = 16'd200;
   localparam logic [CFG_W-1:0] ALARM_DELAY_RESET = 16'd500;

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic              pedal_active;
      logic              hold_one_pressed;
      logic              hold_two_pressed;
      logic              beep_request;
   } req_type;

   typedef struct packed {
      logic dead_man_on;
      logic buzzer_on;
      logic beep_taken;
   } rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0] tolerance_ms;
      logic [CFG_W-1:0] beep_length_ms;
      logic [CFG_W-1:0] alarm_delay_ms;
   } cfg_type;

endpackage

// ===== rtl/dmst_if.sv =====
// Valid/ready channel interfaces for the request and response transactions.
// Depends on dmst_pkg.
interface dmst_req_if;
   import dmst_pkg::*;
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] now_ms;
   logic              pedal_active;
   logic              hold_one_pressed;
   logic              hold_two_pressed;
   logic              beep_request;

   modport source (output valid, output now_ms, output pedal_active,
                   output hold_one_pressed, output hold_two_pressed,
                   output beep_request, input ready);
   modport sink   (input valid, input now_ms, input pedal_active,
                   input hold_one_pressed, input hold_two_pressed,
                   input beep_request, output ready);
endinterface

interface dmst_rsp_if;
   logic valid;
   logic ready;
   logic dead_man_on;
   logic buzzer_on;
   logic beep_taken;

   modport source (output valid, output dead_man_on, output buzzer_on,
                   output beep_taken, input ready);
   modport sink   (input valid, input dead_man_on, input buzzer_on,
                   input beep_taken, output ready);
endinterface

// ===== rtl/dead_man_switch_timer.sv =====
// Dead-man switch timer: input register, supervisor update, response register.
// A request transaction passes through the input register and the response
// register to the response channel; one transaction per cycle is sustained,
// limited only by the response channel's ready. Synchronous reset clears the pipeline and the
// supervisor state and loads tolerance 5000, beep length 200, alarm delay 500.
// Depends on dmst_pkg, dmst_if, dmst_csr, dmst_in_stage and dmst_core.
module dead_man_switch_timer (
   input  logic                           clock,
   input  logic                           reset,
   dmst_req_if.sink                       req_chan,
   dmst_rsp_if.source                     rsp_chan,
   input  logic                           csr_we,
   input  logic [dmst_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dmst_pkg::CFG_W-1:0]     csr_wdata
);
   import dmst_pkg::*;

   cfg_type cfg;
   logic    s1_valid;
   logic    s1_ready;
   req_type s1_data;

   dmst_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dmst_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .s1_valid (s1_valid),
      .s1_data  (s1_data),
      .s1_ready (s1_ready)
   );

   dmst_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .s1_valid (s1_valid),
      .s1_data  (s1_data),
      .s1_ready (s1_ready),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== rtl/dmst_csr.sv =====
// Configuration registers of the dead-man switch timer, written by index.
// Depends on dmst_pkg.
module dmst_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [dmst_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dmst_pkg::CFG_W-1:0]  csr_wdata,
   output dmst_pkg::cfg_type           cfg
);
   import dmst_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TOLERANCE:   cfg_in.tolerance_ms   = csr_wdata;
            CSR_BEEP_LENGTH: cfg_in.beep_length_ms = csr_wdata;
            CSR_ALARM_DELAY: cfg_in.alarm_delay_ms = csr_wdata;
            default:         cfg_in = cfg_ff; // drop writes beyond the map
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tolerance_ms   <= TOLERANCE_RESET;
         cfg_ff.beep_length_ms <= BEEP_LENGTH_RESET;
         cfg_ff.alarm_delay_ms <= ALARM_DELAY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/dmst_in_stage.sv =====
// Input register stage: captures one request transaction per cycle unless a held one waits on s1_ready.
// Depends on dmst_pkg and dmst_req_if.
module dmst_in_stage (
   input  logic              clock,
   input  logic              reset,
   dmst_req_if.sink          req_chan,
   output logic              s1_valid,
   output dmst_pkg::req_type s1_data,
   input  logic              s1_ready
);
   import dmst_pkg::*;

   logic    valid_ff, valid_in;
   req_type data_ff;
   logic    take;

   assign req_chan.ready = !valid_ff || s1_ready;
   assign take           = req_chan.valid && req_chan.ready;
   assign valid_in       = take || (valid_ff && !s1_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff.now_ms           <= req_chan.now_ms;
         data_ff.pedal_active     <= req_chan.pedal_active;
         data_ff.hold_one_pressed <= req_chan.hold_one_pressed;
         data_ff.hold_two_pressed <= req_chan.hold_two_pressed;
         data_ff.beep_request     <= req_chan.beep_request;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_data  = data_ff;

endmodule

// ===== rtl/dmst_core.sv =====
// Supervisor state update and response register of the dead-man switch timer.
// Depends on dmst_pkg and dmst_rsp_if.
module dmst_core (
   input  logic              clock,
   input  logic              reset,
   input  dmst_pkg::cfg_type cfg,
   input  logic              s1_valid,
   input  dmst_pkg::req_type s1_data,
   output logic              s1_ready,
   dmst_rsp_if.source        rsp_chan
);
   import dmst_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_COUNT = 2'd1,
      PH_DONE  = 2'd2
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [TIME_W-1:0] release_start_ff, release_start_in;
   logic [TIME_W-1:0] beep_start_ff, beep_start_in;
   logic              dead_man_ff, dead_man_in;
   logic              buzzer_ff, buzzer_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;

   logic              advance;
   logic              taken;
   logic [TIME_W-1:0] beep_ref;
   logic [TIME_W-1:0] beep_elapsed;
   logic [TIME_W-1:0] alarm_elapsed;
   logic [TIME_W-1:0] release_elapsed;

   assign s1_ready = !out_valid_ff || rsp_chan.ready;
   assign advance  = s1_valid && s1_ready;

   // a beep request restarts the beep clock within the same transaction
   assign beep_ref        = s1_data.beep_request ? s1_data.now_ms : beep_start_ff;
   assign beep_elapsed    = s1_data.now_ms - beep_ref;
   // the alarm delay runs from the stored start; a request is not consumed here
   assign alarm_elapsed   = s1_data.now_ms - beep_start_ff;
   assign release_elapsed = s1_data.now_ms - release_start_ff;

   always_comb begin
      phase_in         = phase_ff;
      release_start_in = release_start_ff;
      beep_start_in    = beep_start_ff;
      dead_man_in      = dead_man_ff;
      buzzer_in        = buzzer_ff;
      taken            = 1'b0;
      if (s1_data.pedal_active) begin
         if (s1_data.hold_one_pressed || s1_data.hold_two_pressed) begin
            dead_man_in = 1'b0;
            buzzer_in   = 1'b0;
            phase_in    = PH_IDLE;
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
                  release_start_in = s1_data.now_ms;
                  phase_in         = PH_COUNT;
               end
               PH_COUNT: begin
                  if (s1_data.beep_request) begin
                     beep_start_in = s1_data.now_ms;
                     buzzer_in     = 1'b1;
                     taken         = 1'b1;
                  end
                  if (beep_elapsed > TIME_W'(cfg.beep_length_ms)) begin
                     buzzer_in = 1'b0;
                  end
                  if (release_elapsed > TIME_W'(cfg.tolerance_ms)) begin
                     dead_man_in   = 1'b1;
                     buzzer_in     = 1'b0;
                     beep_start_in = s1_data.now_ms;
                     phase_in      = PH_DONE;
                  end
               end
               PH_DONE: begin
                  if (alarm_elapsed > TIME_W'(cfg.alarm_delay_ms)) begin
                     buzzer_in = 1'b1;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
      out_in.dead_man_on = dead_man_in;
      out_in.buzzer_on   = buzzer_in;
      out_in.beep_taken  = taken;
   end

   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         release_start_ff <= '0;
         beep_start_ff    <= '0;
         dead_man_ff      <= 1'b0;
         buzzer_ff        <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff         <= phase_in;
            release_start_ff <= release_start_in;
            beep_start_ff    <= beep_start_in;
            dead_man_ff      <= dead_man_in;
            buzzer_ff        <= buzzer_in;
         end
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.dead_man_on = out_ff.dead_man_on;
   assign rsp_chan.buzzer_on   = out_ff.buzzer_on;
   assign rsp_chan.beep_taken  = out_ff.beep_taken;

endmodule

// ===== rtl/dmst_checker.sv =====
// Port-level checks for the dead-man switch timer, bound to the top level.
// Depends on dead_man_switch_timer and its channel interfaces.
module dmst_assertions (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_dead_man_on,
   input logic rsp_buzzer_on,
   input logic rsp_beep_taken
);

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> req_ready)
      else $error("request not ready after reset");

   // a consumed beep drives the buzzer unless the dead-man state fired with it
   a_beep_drives: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beep_taken && !rsp_dead_man_on |-> rsp_buzzer_on)
      else $error("beep taken without buzzer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dead_man_on)
         && $stable(rsp_buzzer_on) && $stable(rsp_beep_taken))
      else $error("stalled response changed");

endmodule

bind dead_man_switch_timer dmst_assertions u_dmst_assertions (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_dead_man_on (rsp_chan.dead_man_on),
   .rsp_buzzer_on   (rsp_chan.buzzer_on),
   .rsp_beep_taken  (rsp_chan.beep_taken)
);
